[rtl/core/bbw_pkg.sv]
package bbw_pkg;

    localparam int MAX_BINS    = 16;
    localparam int MAX_ORDER   = 4;
    localparam int SAMPLE_BITS = 16;

    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int FRAC_W = 16;
    localparam int Z_W    = CNT_W + FRAC_W;
    localparam int Q_W    = Z_W + 1;
    localparam int B_W    = 32;
    localparam int P_W    = Z_W + B_W;
    localparam int W_W    = 16;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 1;
    localparam int KIDX_W = 6;
    localparam int D_W    = 2;
    localparam int DIV_STEPS = Q_W / 2;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] REG_NUM_BINS     = 1'b0;
    localparam logic [IDX_W-1:0] REG_SPLINE_ORDER = 1'b1;

    localparam logic [B_W-1:0] ONE_Q30  = 32'h4000_0000;
    localparam logic [B_W-1:0] HALF_Q15 = 32'h0000_4000;
    localparam logic [W_W-1:0] W_MAX    = 16'h8000;
    localparam logic [31:0]    RECIP3   = 32'hAAAA_AAAB;

    typedef struct packed {
        logic             err;
        logic [Z_W-1:0]   z;
        logic [BIN_W-1:0] j;
        logic [CNT_W-1:0] n;
        logic [ORD_W-1:0] k;
    } bbw_job_t;

    function automatic logic [CNT_W-1:0] span_of(logic [CNT_W-1:0] n, logic [ORD_W-1:0] k);
        return n - CNT_W'(k) + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] knot_at(logic [KIDX_W-1:0] idx,
                                                 logic [CNT_W-1:0] n,
                                                 logic [ORD_W-1:0] k);
        logic [KIDX_W-1:0] kk;
        logic [KIDX_W-1:0] nn;
        logic [KIDX_W-1:0] v;
        kk = KIDX_W'(k);
        nn = KIDX_W'(n);
        v  = idx - kk + KIDX_W'(1);
        if (idx < kk)
            return '0;
        else if (idx < nn)
            return v[CNT_W-1:0];
        else
            return span_of(n, k);
    endfunction

endpackage

[rtl/core/bbw_ifaces.sv]
interface bbw_in_if import bbw_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] row_min;
    logic signed [SAMPLE_BITS-1:0] row_max;

    modport source (output valid, output sample, output row_min, output row_max,
                    input ready);
    modport sink   (input valid, input sample, input row_min, input row_max,
                    output ready);
endinterface

interface bbw_out_if import bbw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] bin_index;
    logic [W_W-1:0]   weight;
    logic             last_bin;
    logic             range_error;

    modport source (output valid, output bin_index, output weight, output last_bin,
                    output range_error, input ready);
    modport sink   (input valid, input bin_index, input weight, input last_bin,
                    input range_error, output ready);
endinterface

[rtl/core/bspline_bin_weights_core.sv]
// b-spline bin weights: each input beat (sample, row_min, row_max) yields num_bins output
// beats, one per bin in bin order, carrying the order-k basis weight in q1.15 over the
// clamped uniform knot vector; last_bin marks the final beat and range_error is the same on
// every beat of a sample. a front stage scales the sample with a radix-4 restoring divider
// and hands the scaled position to a two-entry queue, so it can scale the next samples
// while the back stage is still busy. the back stage runs the cox-de boor recursion on a
// window of MAX_ORDER lanes, one round per order step, then emits one beat per cycle while
// the receiver is ready. the user must write num_bins and spline_order through the config
// port only while the block is idle; the block itself does not enforce this. out-of-range
// values saturate.
module bspline_bin_weights_core import bbw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    bbw_in_if.sink           in_ch,
    bbw_out_if.source        out_ch
);

    logic [CFG_W-1:0] num_bins_reg;
    logic [ORD_W-1:0] spline_order_reg;
    logic [CNT_W-1:0] n_eff;
    logic [ORD_W-1:0] k_sat;
    logic [ORD_W-1:0] k_eff;

    logic     f_valid;
    logic     f_ready;
    bbw_job_t f_job;
    logic     b_valid;
    logic     b_ready;
    bbw_job_t b_job;

    // register file, write only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg     <= CFG_W'(10);
            spline_order_reg <= ORD_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_BINS:     num_bins_reg     <= cfg_data;
                REG_SPLINE_ORDER: spline_order_reg <= cfg_data[ORD_W-1:0];
                default:          ;
            endcase
        end
    end

    // saturate bins to [2, max] and order to [1, max], order not above bins
    always_comb
    begin
        if (num_bins_reg < CFG_W'(2))
            n_eff = CNT_W'(2);
        else if (num_bins_reg > CFG_W'(MAX_BINS))
            n_eff = CNT_W'(MAX_BINS);
        else
            n_eff = CNT_W'(num_bins_reg);

        if (spline_order_reg < ORD_W'(1))
            k_sat = ORD_W'(1);
        else if (spline_order_reg > ORD_W'(MAX_ORDER))
            k_sat = ORD_W'(MAX_ORDER);
        else
            k_sat = spline_order_reg;

        k_eff = (CNT_W'(k_sat) > n_eff) ? n_eff[ORD_W-1:0] : k_sat;
    end

    // scaling and range check
    bbw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .n         (n_eff),
        .k         (k_eff),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // decouples the divider from the recursion and emit
    bbw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    // recursion lanes and per-bin output beats
    bbw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .out_ch    (out_ch)
    );

endmodule

[rtl/core/bbw_front.sv]
module bbw_front import bbw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bbw_in_if.sink           in_ch,
    input  logic [CNT_W-1:0] n,
    input  logic [ORD_W-1:0] k,
    output logic             job_valid,
    input  logic             job_ready,
    output bbw_job_t         job
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

    state_t                        state_reg;
    logic                          hold_valid_reg;
    logic signed [SAMPLE_BITS-1:0] hold_s_reg;
    logic signed [SAMPLE_BITS-1:0] hold_lo_reg;
    logic signed [SAMPLE_BITS-1:0] hold_hi_reg;
    logic [SAMPLE_BITS-1:0]        rem_reg;
    logic [Q_W-1:0]                xb_reg;
    logic [Q_W-1:0]                q_reg;
    logic [SAMPLE_BITS-1:0]        den_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          err_reg;
    logic [CNT_W-1:0]              n_reg;
    logic [ORD_W-1:0]              k_reg;

    logic signed [SAMPLE_BITS:0]   num_s;
    logic signed [SAMPLE_BITS:0]   den_s;
    logic signed [SAMPLE_BITS:0]   a_s;
    logic signed [SAMPLE_BITS:0]   d_s;
    logic [CNT_W-1:0]              span_in;
    logic [Z_W-1:0]                prod;
    logic                          bad;
    logic [SAMPLE_BITS:0]          r1;
    logic [SAMPLE_BITS:0]          r1m;
    logic [SAMPLE_BITS:0]          r2;
    logic [SAMPLE_BITS:0]          r2m;
    logic                          ge1;
    logic                          ge2;
    logic [CNT_W-1:0]              span_out;
    logic [Q_W-1:0]                lastz;
    logic [KIDX_W-1:0]             jsum;
    logic [KIDX_W-1:0]             jmax;

    assign in_ch.ready = !hold_valid_reg;

    // classify the held beat
    always_comb
    begin
        num_s   = hold_s_reg - hold_lo_reg;
        den_s   = hold_hi_reg - hold_lo_reg;
        a_s     = den_s[SAMPLE_BITS] ? -num_s : num_s;
        d_s     = den_s[SAMPLE_BITS] ? -den_s : den_s;
        span_in = span_of(n, k);
        prod    = Z_W'(a_s[SAMPLE_BITS-1:0]) * Z_W'(span_in);
        bad     = (den_s == '0) || a_s[SAMPLE_BITS] ||
                  ({1'b0, prod} >= {d_s[SAMPLE_BITS-1:0], 6'b0});
    end

    // two quotient bits per cycle
    always_comb
    begin
        r1  = {rem_reg, xb_reg[Q_W-1]};
        ge1 = r1 >= {1'b0, den_reg};
        r1m = ge1 ? r1 - {1'b0, den_reg} : r1;
        r2  = {r1m[SAMPLE_BITS-1:0], xb_reg[Q_W-2]};
        ge2 = r2 >= {1'b0, den_reg};
        r2m = ge2 ? r2 - {1'b0, den_reg} : r2;
    end

    always_comb
    begin
        span_out  = span_of(n_reg, k_reg);
        lastz     = {1'b0, span_out, {FRAC_W{1'b0}}};
        jsum      = KIDX_W'(q_reg[Z_W-1:FRAC_W]) + KIDX_W'(k_reg) - KIDX_W'(1);
        jmax      = KIDX_W'(n_reg) - KIDX_W'(1);
        job_valid = (state_reg == ST_OUT);
        job.err   = err_reg || (q_reg > lastz);
        job.z     = q_reg[Z_W-1:0];
        job.j     = (jsum > jmax) ? jmax[BIN_W-1:0] : jsum[BIN_W-1:0];
        job.n     = n_reg;
        job.k     = k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                hold_valid_reg <= 1'b1;
                hold_s_reg     <= in_ch.sample;
                hold_lo_reg    <= in_ch.row_min;
                hold_hi_reg    <= in_ch.row_max;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (hold_valid_reg)
                    begin
                        hold_valid_reg <= 1'b0;
                        n_reg          <= n;
                        k_reg          <= k;
                        err_reg        <= bad;
                        q_reg          <= '0;
                        rem_reg        <= SAMPLE_BITS'(prod[Z_W-1:6]);
                        xb_reg         <= {prod[5:0], {FRAC_W{1'b0}}};
                        den_reg        <= d_s[SAMPLE_BITS-1:0];
                        step_reg       <= '0;
                        state_reg      <= bad ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    q_reg    <= {q_reg[Q_W-3:0], ge1, ge2};
                    xb_reg   <= {xb_reg[Q_W-3:0], 2'b00};
                    rem_reg  <= r2m[SAMPLE_BITS-1:0];
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (job_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/bbw_fifo.sv]
module bbw_fifo import bbw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  bbw_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output bbw_job_t pop_data
);

    bbw_job_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

[rtl/core/bbw_back.sv]
module bbw_back import bbw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  bbw_job_t job,
    bbw_out_if.source out_ch
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_EMIT} state_t;

    state_t           state_reg;
    logic [1:0]       phase_reg;
    logic [ORD_W-1:0] r_reg;
    logic [BIN_W-1:0] bin_reg;
    logic             err_reg;
    logic [Z_W-1:0]   z_reg;
    logic [BIN_W-1:0] j_reg;
    logic [CNT_W-1:0] n_reg;
    logic [ORD_W-1:0] k_reg;
    logic [B_W-1:0]   wnd_reg [MAX_ORDER];
    logic [P_W-1:0]   p1_reg  [MAX_ORDER];
    logic [P_W-1:0]   p2_reg  [MAX_ORDER];
    logic [D_W-1:0]   d1_reg  [MAX_ORDER];
    logic [D_W-1:0]   d2_reg  [MAX_ORDER];
    logic [31:0]      q1_reg  [MAX_ORDER];
    logic [31:0]      q2_reg  [MAX_ORDER];

    logic             out_valid_reg;
    logic [BIN_W-1:0] out_bin_reg;
    logic [W_W-1:0]   out_weight_reg;
    logic             out_last_reg;
    logic             out_err_reg;

    logic [P_W-1:0]   p1_next  [MAX_ORDER];
    logic [P_W-1:0]   p2_next  [MAX_ORDER];
    logic [D_W-1:0]   d1_next  [MAX_ORDER];
    logic [D_W-1:0]   d2_next  [MAX_ORDER];
    logic [31:0]      q1_next  [MAX_ORDER];
    logic [31:0]      q2_next  [MAX_ORDER];
    logic [B_W-1:0]   wnd_next [MAX_ORDER];
    logic             lane_ok  [MAX_ORDER];
    logic [B_W-1:0]   bsel;
    logic [B_W:0]     wsum;
    logic [W_W-1:0]   wround;
    logic             emit_go;

    function automatic logic [31:0] div_small(logic [31:0] q, logic [D_W-1:0] d);
        logic [63:0] m;
        m = 64'(q) * 64'(RECIP3);
        unique case (d)
            2'd1:    return q;
            2'd2:    return q >> 1;
            2'd3:    return {1'b0, m[63:33]};
            default: return '0;
        endcase
    endfunction

    // per-lane terms of one recursion round
    always_comb
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            logic signed [KIDX_W:0] t_s;
            logic [KIDX_W-1:0]      tu;
            logic [CNT_W-1:0]       kt;
            logic [CNT_W-1:0]       kt1;
            logic [CNT_W-1:0]       ktr1;
            logic [CNT_W-1:0]       ktr;
            logic [CNT_W-1:0]       dd1;
            logic [CNT_W-1:0]       dd2;
            logic signed [Z_W+1:0]  diff1;
            logic signed [Z_W+1:0]  diff2;
            logic [Z_W-1:0]         op1;
            logic [Z_W-1:0]         op2;
            logic [B_W-1:0]         b2;
            logic [B_W:0]           sum;
            t_s   = $signed({1'b0, KIDX_W'(j_reg)}) + (KIDX_W+1)'(i) -
                    (KIDX_W+1)'(MAX_ORDER - 1);
            tu    = t_s[KIDX_W-1:0];
            lane_ok[i] = !t_s[KIDX_W];
            kt    = knot_at(tu, n_reg, k_reg);
            kt1   = knot_at(tu + KIDX_W'(1), n_reg, k_reg);
            ktr1  = knot_at(tu + KIDX_W'(r_reg) - KIDX_W'(1), n_reg, k_reg);
            ktr   = knot_at(tu + KIDX_W'(r_reg), n_reg, k_reg);
            dd1   = ktr1 - kt;
            dd2   = ktr - kt1;
            diff1 = $signed({2'b00, z_reg}) - $signed({2'b00, kt, {FRAC_W{1'b0}}});
            diff2 = $signed({2'b00, ktr, {FRAC_W{1'b0}}}) - $signed({2'b00, z_reg});
            op1   = (lane_ok[i] && !diff1[Z_W+1]) ? diff1[Z_W-1:0] : '0;
            op2   = (lane_ok[i] && !diff2[Z_W+1]) ? diff2[Z_W-1:0] : '0;
            b2    = (i < MAX_ORDER - 1) ? wnd_reg[(i + 1) % MAX_ORDER] : '0;
            p1_next[i] = P_W'(op1) * P_W'(wnd_reg[i]);
            p2_next[i] = P_W'(op2) * P_W'(b2);
            d1_next[i] = dd1[D_W-1:0];
            d2_next[i] = dd2[D_W-1:0];
            q1_next[i] = div_small(p1_reg[i][FRAC_W+31:FRAC_W], d1_reg[i]);
            q2_next[i] = div_small(p2_reg[i][FRAC_W+31:FRAC_W], d2_reg[i]);
            sum        = {1'b0, q1_reg[i]} + {1'b0, q2_reg[i]};
            wnd_next[i] = lane_ok[i] ? sum[B_W-1:0] : '0;
        end
    end

    // weight of the bin being emitted, rounded to Q1.15
    always_comb
    begin
        bsel = '0;
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            if (BIN_W'(j_reg + BIN_W'(i) - BIN_W'(MAX_ORDER - 1)) == bin_reg &&
                {1'b0, bin_reg} + (BIN_W+1)'(MAX_ORDER - 1 - i) == {1'b0, j_reg})
                bsel = wnd_reg[i];
        end
        wsum   = {1'b0, bsel} + {1'b0, HALF_Q15};
        wround = (wsum[B_W:15] > (B_W-14)'(W_MAX)) ? W_MAX : wsum[15+W_W-1:15];
    end

    assign emit_go          = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);
    assign job_ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.bin_index   = out_bin_reg;
    assign out_ch.weight      = out_weight_reg;
    assign out_ch.last_bin    = out_last_reg;
    assign out_ch.range_error = out_err_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            p1_reg[i] <= p1_next[i];
            p2_reg[i] <= p2_next[i];
            d1_reg[i] <= d1_next[i];
            d2_reg[i] <= d2_next[i];
            q1_reg[i] <= q1_next[i];
            q2_reg[i] <= q2_next[i];
        end
        if (emit_go)
        begin
            out_bin_reg    <= bin_reg;
            out_weight_reg <= err_reg ? '0 : wround;
            out_last_reg   <= (CNT_W'(bin_reg) == n_reg - CNT_W'(1));
            out_err_reg    <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        err_reg   <= job.err;
                        z_reg     <= job.z;
                        j_reg     <= job.j;
                        n_reg     <= job.n;
                        k_reg     <= job.k;
                        r_reg     <= ORD_W'(2);
                        phase_reg <= 2'd0;
                        bin_reg   <= '0;
                        for (int i = 0; i < MAX_ORDER; i++)
                            wnd_reg[i] <= (i == MAX_ORDER - 1 && !job.err) ? ONE_Q30 : '0;
                        state_reg <= (job.err || job.k == ORD_W'(1)) ? ST_EMIT : ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd2)
                    begin
                        phase_reg <= 2'd0;
                        for (int i = 0; i < MAX_ORDER; i++)
                            wnd_reg[i] <= wnd_next[i];
                        r_reg <= r_reg + ORD_W'(1);
                        if (r_reg == k_reg)
                            state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        bin_reg <= bin_reg + BIN_W'(1);
                        if (CNT_W'(bin_reg) == n_reg - CNT_W'(1))
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/bbw_checker.sv]
module bbw_checker import bbw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [BIN_W-1:0] bin_index,
    input logic [W_W-1:0]   weight,
    input logic             last_bin,
    input logic             range_error
);

    logic [BIN_W-1:0] exp_bin_reg;
    logic             err_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_bin_reg  <= '0;
            err_hold_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            exp_bin_reg <= last_bin ? '0 : bin_index + BIN_W'(1);
            if (bin_index == '0)
                err_hold_reg <= range_error;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_index) && $stable(weight))
        else $error("output beat changed while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bin_index == exp_bin_reg)
        else $error("bin index out of sequence");

    a_err_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bin_index != '0 |-> range_error == err_hold_reg)
        else $error("range flag differs within one sample");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> weight == '0)
        else $error("nonzero weight on flagged sample");

    a_wmax: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= W_MAX)
        else $error("weight above one");

endmodule

bind bspline_bin_weights_core bbw_checker u_bbw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .bin_index   (out_ch.bin_index),
    .weight      (out_ch.weight),
    .last_bin    (out_ch.last_bin),
    .range_error (out_ch.range_error)
);

[tb/bspline_bin_weights_checker.sv]
module bspline_bin_weights_checker import bbw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    bbw_in_if                in_ch,
    bbw_out_if               out_ch,
    output int               fails,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [BIN_W-1:0] bin_index;
        logic [W_W-1:0]   weight;
        logic             last_bin;
        logic             range_error;
    } bin_weight_t;

    bin_weight_t expected_weights[$];
    logic [4:0]  bins_reg;
    logic [2:0]  order_reg;

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    // cox-de boor basis weights for one sample, queued in bin order
    function automatic void queue_bin_weights(logic signed [SAMPLE_BITS-1:0] s,
                                              logic signed [SAMPLE_BITS-1:0] lo,
                                              logic signed [SAMPLE_BITS-1:0] hi);
        longint knot[0:MAX_BINS+MAX_ORDER];
        longint bas[0:MAX_BINS+MAX_ORDER];
        int n, k, span;
        longint num, den, z, zmax, a, c, d1, d2, v, w;
        logic bad;
        bin_weight_t e;
        n = int'(bins_reg);
        if (n < 2) n = 2;
        if (n > MAX_BINS) n = MAX_BINS;
        k = int'(order_reg);
        if (k < 1) k = 1;
        if (k > MAX_ORDER) k = MAX_ORDER;
        if (k > n) k = n;
        span = n - k + 1;
        for (int i = 0; i <= MAX_BINS + MAX_ORDER; i++)
        begin
            bas[i] = 0;
            if (i < k) knot[i] = 0;
            else if (i <= n - 1) knot[i] = i - k + 1;
            else knot[i] = span;
        end
        bad = 1'b0;
        z = 0;
        zmax = longint'(span) << 16;
        den = longint'(hi) - longint'(lo);
        if (den == 0)
            bad = 1'b1;
        else
        begin
            num = (longint'(s) - longint'(lo)) * span * 65536;
            if (den < 0)
            begin
                num = -num;
                den = -den;
            end
            z = fdiv(num, den);
            if (z < 0 || z > zmax)
                bad = 1'b1;
        end
        if (!bad)
        begin
            for (int t = 0; t + 1 < n + k; t++)
            begin
                a = knot[t] << 16;
                c = knot[t+1] << 16;
                if ((z >= a && z < c) || (z == c && t + 1 == n))
                    bas[t] = longint'(1) << 30;
            end
            for (int r = 2; r <= k; r++)
            begin
                for (int t = 0; t < n + k - r; t++)
                begin
                    d1 = knot[t+r-1] - knot[t];
                    d2 = knot[t+r] - knot[t+1];
                    v = 0;
                    if (d1 != 0)
                        v += fdiv((z - (knot[t] << 16)) * bas[t], d1 << 16);
                    if (d2 != 0)
                        v += fdiv(((knot[t+r] << 16) - z) * bas[t+1], d2 << 16);
                    if (v < 0) v = 0;
                    bas[t] = v;
                end
                bas[n+k-r] = 0;
            end
        end
        for (int t = 0; t < n; t++)
        begin
            w = bad ? 0 : ((bas[t] + (longint'(1) << 14)) >>> 15);
            if (w > 32768) w = 32768;
            e.bin_index   = BIN_W'(t);
            e.weight      = W_W'(w);
            e.last_bin    = (t == n - 1);
            e.range_error = bad;
            expected_weights.push_back(e);
        end
    endfunction

    assign pending = expected_weights.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg  <= 5'd10;
            order_reg <= 3'd3;
            fails     <= 0;
            expected_weights.delete();
        end
        else
        begin
            if (cfg_we && cfg_index == REG_NUM_BINS)
                bins_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_SPLINE_ORDER)
                order_reg <= cfg_data[2:0];
            if (in_ch.valid && in_ch.ready)
                queue_bin_weights(in_ch.sample, in_ch.row_min, in_ch.row_max);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_weights.size() == 0)
                begin
                    $error("unexpected beat: bin_index %0d weight %0d",
                           out_ch.bin_index, out_ch.weight);
                    fails <= fails + 1;
                end
                else
                begin
                    bin_weight_t e;
                    e = expected_weights.pop_front();
                    if (out_ch.bin_index !== e.bin_index)
                        $error("bin_index: expected %0d actual %0d", e.bin_index,
                               out_ch.bin_index);
                    if (out_ch.weight !== e.weight)
                        $error("weight: expected %0d actual %0d", e.weight, out_ch.weight);
                    if (out_ch.last_bin !== e.last_bin)
                        $error("last_bin: expected %0d actual %0d", e.last_bin,
                               out_ch.last_bin);
                    if (out_ch.range_error !== e.range_error)
                        $error("range_error: expected %0d actual %0d", e.range_error,
                               out_ch.range_error);
                    if (out_ch.bin_index !== e.bin_index || out_ch.weight !== e.weight ||
                        out_ch.last_bin !== e.last_bin ||
                        out_ch.range_error !== e.range_error)
                        fails <= fails + 1;
                end
            end
        end
    end
endmodule

[tb/bspline_bin_weights_core_tb.sv]
module bspline_bin_weights_core_tb import bbw_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int NUM_PHASES  = 10;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fails;
    int               pending;
    int               hold_len;
    bit               no_idle;
    int               samples_sent;
    int               idle_count;

    bbw_in_if  in_ch();
    bbw_out_if out_ch();

    bspline_bin_weights_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    bspline_bin_weights_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .fails     (fails),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // raw register values per phase; zero, all-ones and order above bins test saturation
    int bins_raw[NUM_PHASES]  = '{2, 16, 16, 0, 31, 3, 7, 12, 5, 9};
    int order_raw[NUM_PHASES] = '{1, 4, 1, 0, 7, 4, 2, 13, 5, 3};

    // receiver: random stall before each beat, plus a single long hold-off
    initial
    begin
        int gap;
        int cnt;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_len > 0)
            begin
                out_ch.ready <= 1'b0;
                cnt = hold_len;
                hold_len = 0;
                repeat (cnt) @(posedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(9);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("FAIL bspline_bin_weights_core");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one input beat; valid stays high across back-to-back beats
    task automatic send_sample(int s, int lo, int hi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(9);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= SAMPLE_BITS'(s);
        in_ch.row_min <= SAMPLE_BITS'(lo);
        in_ch.row_max <= SAMPLE_BITS'(hi);
        do @(posedge clk); while (!in_ch.ready);
        samples_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
    endtask

    // mostly in-range samples of ordered rows, with noise, flat and reversed rows
    task automatic send_random_sample();
        int lo, hi, s, tmp, r;
        r  = $urandom_range(99);
        lo = $signed(16'($urandom));
        hi = $signed(16'($urandom));
        s  = $signed(16'($urandom));
        if (r < 75)
        begin
            if (lo > hi)
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            if ($urandom_range(3) == 0)
                hi = lo + $urandom_range(20);
            if (hi > 32767) hi = 32767;
            s = lo + $urandom_range(hi - lo);
        end
        else if (r < 85)
            ;
        else if (r < 90)
            hi = lo;
        else
            s = ($urandom_range(1) == 0) ? lo : hi;
        send_sample(s, lo, hi);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.sample <= '0;
        in_ch.row_min <= '0;
        in_ch.row_max <= '0;
        hold_len     = 0;
        no_idle      = 1'b0;
        samples_sent = 0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed part at reset settings: ends, knots, flat row, out of range, reversed
        send_sample(0, 0, 100);
        send_sample(100, 0, 100);
        send_sample(50, 0, 100);
        send_sample(25, 0, 200);
        send_sample(-32768, -32768, 32767);
        send_sample(32767, -32768, 32767);
        send_sample(0, -32768, 32767);
        send_sample(7, 7, 7);
        send_sample(-5, 0, 100);
        send_sample(101, 0, 100);
        send_sample(50, 100, 0);
        send_sample(100, 100, 0);
        send_sample(-32768, 32767, -32768);
        send_sample(32767, 32767, 32766);
        send_sample(1, 0, 1);
        send_sample(-1, -2, 5);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_NUM_BINS, bins_raw[p]);
            write_reg(REG_SPLINE_ORDER, order_raw[p]);
            no_idle = (p == 3);
            if (p == 2)
                hold_len = 400;
            send_sample(0, 0, 1000);
            send_sample(1000, 0, 1000);
            for (int i = 0; i < 32; i++)
                send_random_sample();
            drain();
        end

        $display("covered %0d samples over %0d register settings, bins 2..16 and orders 1..4",
                 samples_sent, NUM_PHASES + 1);
        $display("with random stalls, a long output hold-off and back-to-back stretches");
        if (fails == 0)
            $display("PASS bspline_bin_weights_core");
        else
            $display("FAIL bspline_bin_weights_core");
        $finish;
    end
endmodule

[sim.f]
rtl/core/bbw_pkg.sv
rtl/core/bbw_ifaces.sv
rtl/core/bbw_front.sv
rtl/core/bbw_fifo.sv
rtl/core/bbw_back.sv
rtl/core/bspline_bin_weights_core.sv
rtl/core/bbw_checker.sv
tb/bspline_bin_weights_checker.sv
tb/bspline_bin_weights_core_tb.sv
